[hw/rtl/bilinear_image_scaler_macros.svh]
// Assertion macros shared by the checker file of the image scaler.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef BILINEAR_IMAGE_SCALER_MACROS_SVH
`define BILINEAR_IMAGE_SCALER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BIS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BIS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bis_pkg.sv]
`default_nettype none

package bis_pkg;

  // Fixed field widths of the request, result and configuration channels.
  localparam int COORD_W    = 12;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 3 * CHAN_W;
  localparam int SRC_DIM_W  = 10;
  localparam int DST_DIM_W  = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Request opcodes.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_WIDTH  = 2'd0,
    CFG_SOURCE_HEIGHT = 2'd1,
    CFG_TARGET_WIDTH  = 2'd2,
    CFG_TARGET_HEIGHT = 2'd3
  } cfg_reg_t;

  // Sequencer states of a compute request.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_ADDR,
    ST_RD00,
    ST_RD01,
    ST_RD10,
    ST_RD11,
    ST_BOT,
    ST_VERT,
    ST_EDGE
  } bis_state_t;

endpackage

`default_nettype wire

[hw/rtl/bilinear_image_scaler.sv]
`default_nettype none
// Channel    Direction  Signals                                        Handshake
// request    in         opcode coord_x coord_y in_red in_green in_blue  start & !busy
// result     out        out_red out_green out_blue                      done (one cycle)
// config     in         cfg_index cfg_data                              cfg_valid & cfg_ready
//
// A load request with coordinates in range writes the pixel store at the edge that accepts it; busy stays low.
// A compute request keeps busy high through a multiply step, 22 + FRACTION_BITS restoring-divider
// steps, an address step and four reads of the single-ported pixel store with the blends;
// at the right or bottom edge one read is made. done pulses in the first cycle with busy
// low, in which a new request can already be taken; reset is sync.

module bilinear_image_scaler #(
  parameter int MAX_SOURCE_WIDTH  = 512,
  parameter int MAX_SOURCE_HEIGHT = 512,
  parameter int FRACTION_BITS     = 8
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  wire                          opcode,
  input  wire  [bis_pkg::COORD_W-1:0]  coord_x,
  input  wire  [bis_pkg::COORD_W-1:0]  coord_y,
  input  wire  [bis_pkg::CHAN_W-1:0]   in_red,
  input  wire  [bis_pkg::CHAN_W-1:0]   in_green,
  input  wire  [bis_pkg::CHAN_W-1:0]   in_blue,
  output logic                         done,
  output logic [bis_pkg::CHAN_W-1:0]   out_red,
  output logic [bis_pkg::CHAN_W-1:0]   out_green,
  output logic [bis_pkg::CHAN_W-1:0]   out_blue,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [bis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [bis_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bis_pkg::*;

  localparam int FB     = FRACTION_BITS;
  localparam int XW     = $clog2(MAX_SOURCE_WIDTH);
  localparam int YW     = $clog2(MAX_SOURCE_HEIGHT);
  localparam int DEPTH  = MAX_SOURCE_WIDTH * MAX_SOURCE_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int PROD_W = COORD_W + SRC_DIM_W;
  localparam int NUM_W  = PROD_W + FB;
  localparam int REM_W  = DST_DIM_W;
  localparam int CNT_W  = $clog2(NUM_W);

  localparam logic [AW-1:0]      ROW_STRIDE = AW'(MAX_SOURCE_WIDTH);
  localparam logic [COORD_W:0]   MSW_C      = (COORD_W + 1)'(MAX_SOURCE_WIDTH);
  localparam logic [COORD_W:0]   MSH_C      = (COORD_W + 1)'(MAX_SOURCE_HEIGHT);
  localparam logic [PROD_W:0]    MSW_L      = (PROD_W + 1)'(MAX_SOURCE_WIDTH);
  localparam logic [PROD_W:0]    MSH_L      = (PROD_W + 1)'(MAX_SOURCE_HEIGHT);
  localparam logic [PROD_W-1:0]  X_MAX      = PROD_W'(MAX_SOURCE_WIDTH - 1);
  localparam logic [PROD_W-1:0]  Y_MAX      = PROD_W'(MAX_SOURCE_HEIGHT - 1);
  localparam logic [CNT_W-1:0]   LAST_STEP  = CNT_W'(NUM_W - 1);

  // One restoring-division step: next remainder, shifted dividend with new quotient bit.
  function automatic logic [REM_W+NUM_W-1:0] div_step(input logic [REM_W-1:0] rem,
                                                      input logic [NUM_W-1:0] quo,
                                                      input logic [DST_DIM_W-1:0] den);
    logic [REM_W:0]   trial;
    logic [REM_W:0]   diff;
    logic             q_bit;
    logic [REM_W-1:0] rem_n;
    trial = {rem, quo[NUM_W-1]};
    diff  = trial - {1'b0, den};
    q_bit = (trial >= {1'b0, den});
    rem_n = q_bit ? diff[REM_W-1:0] : trial[REM_W-1:0];
    return {rem_n, quo[NUM_W-2:0], q_bit};
  endfunction

  // One channel blend: floor(b + frac * (f - b) / 2^FB).
  function automatic logic [CHAN_W-1:0] blend_chan(input logic [CHAN_W-1:0] b,
                                                   input logic [CHAN_W-1:0] f,
                                                   input logic [FB-1:0] frac);
    logic signed [CHAN_W:0]      diff;
    logic signed [FB+CHAN_W+1:0] prod;
    logic signed [FB+CHAN_W+1:0] acc;
    diff = $signed({1'b0, f}) - $signed({1'b0, b});
    prod = $signed({1'b0, frac}) * diff;
    acc  = $signed({2'b00, b, {FB{1'b0}}}) + prod;
    return acc[FB+CHAN_W-1:FB];
  endfunction

  function automatic logic [PIX_W-1:0] blend_pix(input logic [PIX_W-1:0] b,
                                                 input logic [PIX_W-1:0] f,
                                                 input logic [FB-1:0] frac);
    return {blend_chan(b[23:16], f[23:16], frac),
            blend_chan(b[15:8],  f[15:8],  frac),
            blend_chan(b[7:0],   f[7:0],   frac)};
  endfunction

  // Configuration registers.
  logic [SRC_DIM_W-1:0] source_width;
  logic [SRC_DIM_W-1:0] source_height;
  logic [DST_DIM_W-1:0] target_width;
  logic [DST_DIM_W-1:0] target_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SRC_DIM_W'(512);
      source_height <= SRC_DIM_W'(512);
      target_width  <= DST_DIM_W'(512);
      target_height <= DST_DIM_W'(512);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SOURCE_WIDTH:  source_width  <= cfg_data[SRC_DIM_W-1:0];
        CFG_SOURCE_HEIGHT: source_height <= cfg_data[SRC_DIM_W-1:0];
        CFG_TARGET_WIDTH:  target_width  <= cfg_data[DST_DIM_W-1:0];
        CFG_TARGET_HEIGHT: target_height <= cfg_data[DST_DIM_W-1:0];
      endcase
    end
  end

  // Sequencer state and datapath registers.
  bis_state_t state, state_next;

  logic [COORD_W-1:0]   req_x;
  logic [COORD_W-1:0]   req_y;
  logic [DST_DIM_W-1:0] den_x;
  logic [DST_DIM_W-1:0] den_y;
  logic [REM_W-1:0]     rem_x;
  logic [REM_W-1:0]     rem_y;
  logic [NUM_W-1:0]     quo_x;
  logic [NUM_W-1:0]     quo_y;
  logic [CNT_W-1:0]     div_count;
  logic [XW-1:0]        pos_x;
  logic [YW-1:0]        pos_y;
  logic [FB-1:0]        frac_x;
  logic [FB-1:0]        frac_y;
  logic                 at_edge;
  logic [PIX_W-1:0]     pix00;
  logic [PIX_W-1:0]     pix10;
  logic [PIX_W-1:0]     top;
  logic [PIX_W-1:0]     bot;

  logic accept;
  logic load_hit;
  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign load_hit = accept && (opcode == OP_LOAD) &&
                    ({1'b0, coord_x} < MSW_C) && ({1'b0, coord_y} < MSH_C);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control: next state, read position and blend operand selection.
  logic              rd_row_inc;
  logic              rd_col_inc;
  logic [PIX_W-1:0]  blend_b;
  logic [PIX_W-1:0]  blend_f;
  logic [FB-1:0]     blend_frac;
  logic [PIX_W-1:0]  mem_rdata;

  always_comb begin
    state_next = state;
    rd_row_inc = 1'b0;
    rd_col_inc = 1'b0;
    blend_b    = pix00;
    blend_f    = mem_rdata;
    blend_frac = frac_x;
    unique case (state)
      ST_IDLE: begin
        if (accept && (opcode == OP_COMPUTE)) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_DIV;
      ST_DIV: begin
        if (div_count == LAST_STEP) begin
          state_next = ST_ADDR;
        end
      end
      ST_ADDR: state_next = ST_RD00;
      ST_RD00: state_next = at_edge ? ST_EDGE : ST_RD01;
      ST_RD01: begin
        rd_col_inc = 1'b1;
        state_next = ST_RD10;
      end
      ST_RD10: begin
        rd_row_inc = 1'b1;
        state_next = ST_RD11;
      end
      ST_RD11: begin
        rd_row_inc = 1'b1;
        rd_col_inc = 1'b1;
        state_next = ST_BOT;
      end
      ST_BOT: begin
        blend_b    = pix10;
        state_next = ST_VERT;
      end
      ST_VERT: begin
        blend_b    = top;
        blend_f    = bot;
        blend_frac = frac_y;
        state_next = ST_IDLE;
      end
      ST_EDGE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Shared blend unit.
  logic [PIX_W-1:0] blend_out;
  assign blend_out = blend_pix(blend_b, blend_f, blend_frac);

  // Coordinate mapping and edge check on the finished quotients.
  logic [PROD_W-1:0] int_x;
  logic [PROD_W-1:0] int_y;
  logic [PROD_W:0]   lim_w;
  logic [PROD_W:0]   lim_h;
  logic [PROD_W:0]   int_x_p1;
  logic [PROD_W:0]   int_y_p1;
  assign int_x    = quo_x[NUM_W-1:FB];
  assign int_y    = quo_y[NUM_W-1:FB];
  assign int_x_p1 = {1'b0, int_x} + 1'b1;
  assign int_y_p1 = {1'b0, int_y} + 1'b1;
  assign lim_w    = ((PROD_W + 1)'(source_width) < MSW_L) ?
                    (PROD_W + 1)'(source_width) : MSW_L;
  assign lim_h    = ((PROD_W + 1)'(source_height) < MSH_L) ?
                    (PROD_W + 1)'(source_height) : MSH_L;

  logic [REM_W+NUM_W-1:0] step_x;
  logic [REM_W+NUM_W-1:0] step_y;
  assign step_x = div_step(rem_x, quo_x, den_x);
  assign step_y = div_step(rem_y, quo_y, den_y);

  always_ff @(posedge clk) begin
    if (accept) begin
      req_x <= coord_x;
      req_y <= coord_y;
    end
    unique case (state)
      // Numerators coord * size * 2^FB; a zero target size counts as one.
      ST_MUL: begin
        quo_x     <= {PROD_W'(req_x) * PROD_W'(source_width), {FB{1'b0}}};
        quo_y     <= {PROD_W'(req_y) * PROD_W'(source_height), {FB{1'b0}}};
        rem_x     <= '0;
        rem_y     <= '0;
        den_x     <= (target_width == '0) ? DST_DIM_W'(1) : target_width;
        den_y     <= (target_height == '0) ? DST_DIM_W'(1) : target_height;
        div_count <= '0;
      end
      ST_DIV: begin
        {rem_x, quo_x} <= step_x;
        {rem_y, quo_y} <= step_y;
        div_count      <= div_count + 1'b1;
      end
      // Saturate the integer (floor) position into the store and keep the fractions.
      ST_ADDR: begin
        pos_x   <= (int_x > X_MAX) ? X_MAX[XW-1:0] : int_x[XW-1:0];
        pos_y   <= (int_y > Y_MAX) ? Y_MAX[YW-1:0] : int_y[YW-1:0];
        frac_x  <= quo_x[FB-1:0];
        frac_y  <= quo_y[FB-1:0];
        at_edge <= (int_x_p1 >= lim_w) || (int_y_p1 >= lim_h);
      end
      ST_RD01: pix00 <= mem_rdata;
      ST_RD10: top   <= blend_out;
      ST_RD11: pix10 <= mem_rdata;
      ST_BOT:  bot   <= blend_out;
      default: ;
    endcase
  end

  // Result register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_VERT) || (state == ST_EDGE);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_VERT) begin
      {out_red, out_green, out_blue} <= blend_out;
    end else if (state == ST_EDGE) begin
      {out_red, out_green, out_blue} <= mem_rdata;
    end
  end

  // Pixel store: single port, row-major, registered read.
  logic [PIX_W-1:0] pixel_mem [DEPTH];
  logic [AW-1:0]    rd_row;
  logic [AW-1:0]    rd_col;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    mem_addr;

  assign rd_row   = AW'(pos_y) + AW'(rd_row_inc);
  assign rd_col   = AW'(pos_x) + AW'(rd_col_inc);
  assign rd_addr  = rd_row * ROW_STRIDE + rd_col;
  assign wr_addr  = AW'(coord_y) * ROW_STRIDE + AW'(coord_x);
  assign mem_addr = load_hit ? wr_addr : rd_addr;

  always_ff @(posedge clk) begin
    if (load_hit) begin
      pixel_mem[mem_addr] <= {in_red, in_green, in_blue};
    end
    mem_rdata <= pixel_mem[mem_addr];
  end

endmodule

`default_nettype wire

[hw/rtl/bis_checker.sv]
`default_nettype none
`include "bilinear_image_scaler_macros.svh"

module bis_checker (
  input wire clk,
  input wire rst,
  input wire start,
  input wire busy,
  input wire opcode,
  input wire done
);
  import bis_pkg::*;

  // A result only follows a compute that kept the block busy.
  `BIS_ASSERT_SAME(a_done_after_busy, done, $past(busy), "result without a busy compute")

  // A load finishes in its own cycle and never yields a result.
  `BIS_ASSERT_NEXT(a_load_quiet, start && !busy && (opcode == OP_LOAD), !busy && !done, "load request made the block busy or gave a result")

  // A compute request occupies the block.
  `BIS_ASSERT_NEXT(a_compute_busy, start && !busy && (opcode == OP_COMPUTE), busy, "compute request not taken up")

  // Result strobes never come back to back.
  `BIS_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe longer than one cycle")

endmodule

bind bilinear_image_scaler bis_checker u_bis_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .opcode (opcode),
  .done   (done)
);

`default_nettype wire
